FILE: hw/rtl/mer_pkg.sv
// Shared types, constants and the microcode program of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

  localparam int DEC_W   = 48;
  localparam int PIX_W   = 12;
  localparam int COLOR_W = 4;
  localparam int UPC_W   = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 4'hF;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COLOR = 3'd4;

  // Quadrant of an emitted pixel: bit 1 negates x, bit 0 negates y.
  localparam logic [1:0] QD_PP = 2'b00;
  localparam logic [1:0] QD_PM = 2'b01;
  localparam logic [1:0] QD_MP = 2'b10;
  localparam logic [1:0] QD_MM = 2'b11;

  typedef enum logic [1:0] {WT_NONE, WT_IN, WT_OUT} wait_t;
  typedef enum logic [3:0] {
    BR_NEXT, BR_GOTO, BR_RESTART, BR_NOT_ACTIVE, BR_REGION2,
    BR_ZERO_RAD, BR_NOT_LE, BR_DEC_NEG, BR_DEC_LE0
  } br_t;
  typedef enum logic [2:0] {A_RX, A_RY, A_RX2, A_RY2, A_PROD} a_sel_t;
  typedef enum logic [2:0] {B_RX, B_RY, B_SX, B_SY, B_TX, B_TY} b_sel_t;
  typedef enum logic [1:0] {ALU_NOP, ALU_LOAD, ALU_ADD, ALU_SUB} alu_op_t;
  typedef enum logic [2:0] {
    SRC_P, SRC_P2, SRC_P4, SRC_P8, SRC_RX2_4, SRC_RX2_Q, SRC_RY2
  } alu_src_t;
  typedef enum logic [1:0] {SX_HOLD, SX_CLR, SX_INC} sx_op_t;
  typedef enum logic [1:0] {SY_HOLD, SY_LOAD, SY_DEC} sy_op_t;
  typedef enum logic [2:0] {FL_NONE, FL_START, FL_STOP, FL_REGION2, FL_CHECK} flag_op_t;

  typedef struct packed {
    wait_t            wt;
    logic             mul_en;
    a_sel_t           a_sel;
    b_sel_t           b_sel;
    logic             t_load;
    logic             rx2_load;
    logic             ry2_load;
    alu_op_t          alu_op;
    alu_src_t         alu_src;
    sx_op_t           sx_op;
    sy_op_t           sy_op;
    flag_op_t         flag_op;
    logic             emit;
    logic [1:0]       quad;
    br_t              br;
    logic [UPC_W-1:0] target;
  } ucw_t;

  // Program addresses.
  localparam logic [UPC_W-1:0] PC_IDLE      = 6'd0;
  localparam logic [UPC_W-1:0] PC_SQ_RX     = 6'd1;
  localparam logic [UPC_W-1:0] PC_SQ_RY     = 6'd2;
  localparam logic [UPC_W-1:0] PC_DISPATCH  = 6'd3;
  localparam logic [UPC_W-1:0] PC_CHK_ACT   = 6'd4;
  localparam logic [UPC_W-1:0] PC_CHK_REG   = 6'd5;
  localparam logic [UPC_W-1:0] PC_R1_MX     = 6'd6;
  localparam logic [UPC_W-1:0] PC_R1_MY     = 6'd7;
  localparam logic [UPC_W-1:0] PC_R1_TEST   = 6'd8;
  localparam logic [UPC_W-1:0] PC_R1_INCX   = 6'd9;
  localparam logic [UPC_W-1:0] PC_R1_MX2    = 6'd10;
  localparam logic [UPC_W-1:0] PC_R1_DECY   = 6'd11;
  localparam logic [UPC_W-1:0] PC_R1_MY2    = 6'd12;
  localparam logic [UPC_W-1:0] PC_R1_SUB    = 6'd13;
  localparam logic [UPC_W-1:0] PC_R1_ADDRY  = 6'd14;
  localparam logic [UPC_W-1:0] PC_R1_NEG    = 6'd15;
  localparam logic [UPC_W-1:0] PC_TR0       = 6'd16;
  localparam logic [UPC_W-1:0] PC_TR1       = 6'd17;
  localparam logic [UPC_W-1:0] PC_TR2       = 6'd18;
  localparam logic [UPC_W-1:0] PC_TR3       = 6'd19;
  localparam logic [UPC_W-1:0] PC_TR4       = 6'd20;
  localparam logic [UPC_W-1:0] PC_TR5       = 6'd21;
  localparam logic [UPC_W-1:0] PC_TR6       = 6'd22;
  localparam logic [UPC_W-1:0] PC_R2_TEST   = 6'd23;
  localparam logic [UPC_W-1:0] PC_R2_Y0     = 6'd24;
  localparam logic [UPC_W-1:0] PC_R2_Y1     = 6'd25;
  localparam logic [UPC_W-1:0] PC_R2_XY0    = 6'd26;
  localparam logic [UPC_W-1:0] PC_R2_XY1    = 6'd27;
  localparam logic [UPC_W-1:0] PC_R2_XY2    = 6'd28;
  localparam logic [UPC_W-1:0] PC_R2_XY3    = 6'd29;
  localparam logic [UPC_W-1:0] PC_CHECK     = 6'd30;
  localparam logic [UPC_W-1:0] PC_EMIT0     = 6'd31;
  localparam logic [UPC_W-1:0] PC_EMIT1     = 6'd32;
  localparam logic [UPC_W-1:0] PC_EMIT2     = 6'd33;
  localparam logic [UPC_W-1:0] PC_EMIT3     = 6'd34;
  localparam logic [UPC_W-1:0] PC_START0    = 6'd35;
  localparam logic [UPC_W-1:0] PC_START1    = 6'd36;
  localparam logic [UPC_W-1:0] PC_START2    = 6'd37;
  localparam logic [UPC_W-1:0] PC_START3    = 6'd38;
  localparam logic [UPC_W-1:0] PC_ZERO      = 6'd39;

  localparam ucw_t UCW_NOP = '{
    wt: WT_NONE, mul_en: 1'b0, a_sel: A_RX, b_sel: B_RX, t_load: 1'b0,
    rx2_load: 1'b0, ry2_load: 1'b0, alu_op: ALU_NOP, alu_src: SRC_P,
    sx_op: SX_HOLD, sy_op: SY_HOLD, flag_op: FL_NONE, emit: 1'b0,
    quad: QD_PP, br: BR_NEXT, target: PC_IDLE
  };

  // The control store. Every multiply lands in the product register at the end of its step.
  function automatic ucw_t ucode_word(input logic [UPC_W-1:0] addr);
    ucw_t w;
    w = UCW_NOP;
    case (addr)
      PC_IDLE: begin
        w.wt = WT_IN;
      end
      PC_SQ_RX: begin
        w.mul_en = 1'b1; w.a_sel = A_RX; w.b_sel = B_RX;
      end
      PC_SQ_RY: begin
        w.rx2_load = 1'b1;
        w.mul_en = 1'b1; w.a_sel = A_RY; w.b_sel = B_RY;
      end
      PC_DISPATCH: begin
        w.ry2_load = 1'b1;
        w.br = BR_RESTART; w.target = PC_START0;
      end
      PC_CHK_ACT: begin
        w.br = BR_NOT_ACTIVE; w.target = PC_IDLE;
      end
      PC_CHK_REG: begin
        w.br = BR_REGION2; w.target = PC_R2_TEST;
      end
      PC_R1_MX: begin
        w.mul_en = 1'b1; w.a_sel = A_RY2; w.b_sel = B_SX;
      end
      PC_R1_MY: begin
        w.t_load = 1'b1;
        w.mul_en = 1'b1; w.a_sel = A_RX2; w.b_sel = B_SY;
      end
      PC_R1_TEST: begin
        w.br = BR_NOT_LE; w.target = PC_TR0;
      end
      PC_R1_INCX: begin
        w.sx_op = SX_INC;
      end
      PC_R1_MX2: begin
        w.mul_en = 1'b1; w.a_sel = A_RY2; w.b_sel = B_SX;
        w.br = BR_DEC_NEG; w.target = PC_R1_NEG;
      end
      PC_R1_DECY: begin
        w.sy_op = SY_DEC;
        w.alu_op = ALU_ADD; w.alu_src = SRC_P2;
      end
      PC_R1_MY2: begin
        w.mul_en = 1'b1; w.a_sel = A_RX2; w.b_sel = B_SY;
      end
      PC_R1_SUB: begin
        w.alu_op = ALU_SUB; w.alu_src = SRC_P2;
      end
      PC_R1_ADDRY: begin
        w.alu_op = ALU_ADD; w.alu_src = SRC_RY2;
        w.br = BR_GOTO; w.target = PC_CHECK;
      end
      PC_R1_NEG: begin
        w.alu_op = ALU_ADD; w.alu_src = SRC_P2;
        w.br = BR_GOTO; w.target = PC_R1_ADDRY;
      end
      PC_TR0: begin
        w.mul_en = 1'b1; w.a_sel = A_RY2; w.b_sel = B_TX;
      end
      PC_TR1: begin
        w.mul_en = 1'b1; w.a_sel = A_PROD; w.b_sel = B_TX;
      end
      PC_TR2: begin
        w.alu_op = ALU_LOAD; w.alu_src = SRC_P;
        w.mul_en = 1'b1; w.a_sel = A_RX2; w.b_sel = B_TY;
      end
      PC_TR3: begin
        w.mul_en = 1'b1; w.a_sel = A_PROD; w.b_sel = B_TY;
      end
      PC_TR4: begin
        w.alu_op = ALU_ADD; w.alu_src = SRC_P4;
        w.mul_en = 1'b1; w.a_sel = A_RX2; w.b_sel = B_RY;
      end
      PC_TR5: begin
        w.mul_en = 1'b1; w.a_sel = A_PROD; w.b_sel = B_RY;
      end
      PC_TR6: begin
        w.alu_op = ALU_SUB; w.alu_src = SRC_P4;
        w.flag_op = FL_REGION2;
      end
      PC_R2_TEST: begin
        w.sy_op = SY_DEC;
        w.br = BR_DEC_LE0; w.target = PC_R2_XY0;
      end
      PC_R2_Y0: begin
        w.mul_en = 1'b1; w.a_sel = A_RX2; w.b_sel = B_SY;
        w.alu_op = ALU_ADD; w.alu_src = SRC_RX2_4;
      end
      PC_R2_Y1: begin
        w.alu_op = ALU_SUB; w.alu_src = SRC_P8;
        w.br = BR_GOTO; w.target = PC_CHECK;
      end
      PC_R2_XY0: begin
        w.sx_op = SX_INC;
        w.alu_op = ALU_ADD; w.alu_src = SRC_RX2_4;
      end
      PC_R2_XY1: begin
        w.mul_en = 1'b1; w.a_sel = A_RY2; w.b_sel = B_SX;
      end
      PC_R2_XY2: begin
        w.alu_op = ALU_ADD; w.alu_src = SRC_P8;
        w.mul_en = 1'b1; w.a_sel = A_RX2; w.b_sel = B_SY;
      end
      PC_R2_XY3: begin
        w.alu_op = ALU_SUB; w.alu_src = SRC_P8;
        w.br = BR_GOTO; w.target = PC_CHECK;
      end
      PC_CHECK: begin
        w.flag_op = FL_CHECK;
      end
      PC_EMIT0: begin
        w.wt = WT_OUT; w.emit = 1'b1; w.quad = QD_PP;
      end
      PC_EMIT1: begin
        w.wt = WT_OUT; w.emit = 1'b1; w.quad = QD_PM;
      end
      PC_EMIT2: begin
        w.wt = WT_OUT; w.emit = 1'b1; w.quad = QD_MP;
      end
      PC_EMIT3: begin
        w.wt = WT_OUT; w.emit = 1'b1; w.quad = QD_MM;
        w.br = BR_GOTO; w.target = PC_IDLE;
      end
      PC_START0: begin
        w.mul_en = 1'b1; w.a_sel = A_RX2; w.b_sel = B_RY;
        w.br = BR_ZERO_RAD; w.target = PC_ZERO;
      end
      PC_START1: begin
        w.alu_op = ALU_LOAD; w.alu_src = SRC_RY2;
        w.sx_op = SX_CLR; w.sy_op = SY_LOAD; w.flag_op = FL_START;
      end
      PC_START2: begin
        w.alu_op = ALU_SUB; w.alu_src = SRC_P;
      end
      PC_START3: begin
        w.alu_op = ALU_ADD; w.alu_src = SRC_RX2_Q;
        w.br = BR_GOTO; w.target = PC_EMIT0;
      end
      PC_ZERO: begin
        w.flag_op = FL_STOP;
        w.br = BR_GOTO; w.target = PC_IDLE;
      end
      default: begin
        w.br = BR_GOTO; w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/midpoint_ellipse_rasterizer_unit.sv
// A word's four pixels leave the output register one per cycle while ready. Words are
// taken one at a time: each runs its microcode path, which differs for a restart and for
// an advance in region one, in region two or at the region change, and whose length sets
// the throughput since all products share one multiplier; a word that plots nothing takes
// a shorter path. The synchronous reset clears the sequencer, curve state and configuration
// registers (color 15), leaving the unit idle.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_unit #(
  parameter int RADIUS_BITS = 9,
  parameter int COORD_BITS  = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [mer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [mer_pkg::PIX_W-1:0] pixel_x,
  output logic signed [mer_pkg::PIX_W-1:0] pixel_y,
  output logic [mer_pkg::COLOR_W-1:0] color_out,
  output logic                        last_of_point,
  output logic                        curve_done
);

  import mer_pkg::*;

  // Operand widths. The multiplier's second operand is signed and wide enough for
  // 2x+1, y-1 and either radius.
  localparam int MAXW = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int BW   = MAXW + 2;
  localparam int RW2  = 2 * RADIUS_BITS;
  localparam int EW   = COORD_BITS + PIX_W;
  localparam int YW   = COORD_BITS + RADIUS_BITS;

  // Configuration registers.
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;
  logic [COLOR_W-1:0]     pixel_color;

  // Curve state and datapath registers.
  logic [COORD_BITS-1:0] step_x;
  logic [COORD_BITS-1:0] step_y;
  logic [DEC_W-1:0]      decision;
  logic [DEC_W-1:0]      decision_next;
  logic                  in_region_two;
  logic                  active;
  logic                  final_point;
  logic                  restart_item;
  logic [RW2-1:0]        rx_sq;
  logic [RW2-1:0]        ry_sq;
  logic [DEC_W-1:0]      prod;
  logic [DEC_W-1:0]      hold;

  // Sequencer.
  logic [UPC_W-1:0] pc;
  ucw_t             uw;
  logic             stall;
  logic             take;
  logic             out_free;

  // Multiplier and adder operands.
  logic [DEC_W-1:0]         a_op;
  logic signed [BW-1:0]     b_op;
  logic signed [DEC_W+BW:0] mul_full;
  logic [DEC_W-1:0]         alu_src_val;
  logic [YW-1:0]            ry_ext;

  // Pixel arithmetic.
  logic [EW-1:0] cx_ext;
  logic [EW-1:0] cy_ext;
  logic [EW-1:0] sx_ext;
  logic [EW-1:0] sy_ext;
  logic [EW-1:0] sum_x;
  logic [EW-1:0] sum_y;

  // The control word for the current step comes straight out of the program table.
  always_comb begin
    uw = ucode_word(pc);
  end

  // A step that waits on a handshake does nothing until its partner is there.
  // The output register frees up in the same cycle its word is taken.
  assign out_free = !out_valid || out_ready;
  assign stall    = ((uw.wt == WT_IN) && !in_valid) || ((uw.wt == WT_OUT) && !out_free);
  assign in_ready = (uw.wt == WT_IN);

  always_comb begin
    case (uw.br)
      BR_NEXT:       take = 1'b0;
      BR_GOTO:       take = 1'b1;
      BR_RESTART:    take = restart_item;
      BR_NOT_ACTIVE: take = !active;
      BR_REGION2:    take = in_region_two;
      BR_ZERO_RAD:   take = (radius_x == '0) || (radius_y == '0);
      // In region one the block steps while ry^2*x <= rx^2*y; both products are exact here.
      BR_NOT_LE:     take = !(hold <= prod);
      BR_DEC_NEG:    take = decision[DEC_W-1];
      BR_DEC_LE0:    take = decision[DEC_W-1] || (decision == '0);
      default:       take = 1'b0;
    endcase
  end

  // Shared multiplier. Only the low 48 bits of any product are kept, which is all the
  // wrapping decision arithmetic needs; the operands of the region-one test never exceed them.
  always_comb begin
    case (uw.a_sel)
      A_RX:    a_op = DEC_W'(radius_x);
      A_RY:    a_op = DEC_W'(radius_y);
      A_RX2:   a_op = DEC_W'(rx_sq);
      A_RY2:   a_op = DEC_W'(ry_sq);
      A_PROD:  a_op = prod;
      default: a_op = prod;
    endcase
    case (uw.b_sel)
      B_RX:    b_op = BW'(radius_x);
      B_RY:    b_op = BW'(radius_y);
      B_SX:    b_op = BW'(step_x);
      B_SY:    b_op = BW'(step_y);
      B_TX:    b_op = (BW'(step_x) << 1) | BW'(1);
      B_TY:    b_op = BW'(step_y) - BW'(1);
      default: b_op = BW'(step_y);
    endcase
    mul_full = $signed({1'b0, a_op}) * b_op;
  end

  // Decision adder.
  always_comb begin
    case (uw.alu_src)
      SRC_P:     alu_src_val = prod;
      SRC_P2:    alu_src_val = prod << 1;
      SRC_P4:    alu_src_val = prod << 2;
      SRC_P8:    alu_src_val = prod << 3;
      SRC_RX2_4: alu_src_val = DEC_W'(rx_sq) << 2;
      SRC_RX2_Q: alu_src_val = DEC_W'(rx_sq >> 2);
      SRC_RY2:   alu_src_val = DEC_W'(ry_sq);
      default:   alu_src_val = prod;
    endcase
    case (uw.alu_op)
      ALU_NOP:  decision_next = decision;
      ALU_LOAD: decision_next = alu_src_val;
      ALU_ADD:  decision_next = decision + alu_src_val;
      ALU_SUB:  decision_next = decision - alu_src_val;
      default:  decision_next = decision;
    endcase
  end

  assign ry_ext = YW'(radius_y);

  // Pixel coordinates wrap to 12 bits; sums are formed wide and cut back.
  always_comb begin
    cx_ext = EW'(center_x);
    cy_ext = EW'(center_y);
    sx_ext = EW'(step_x);
    sy_ext = EW'(step_y);
    sum_x  = uw.quad[1] ? (cx_ext - sx_ext) : (cx_ext + sx_ext);
    sum_y  = uw.quad[0] ? (cy_ext - sy_ext) : (cy_ext + sy_ext);
  end

  // Configuration and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      radius_x      <= '0;
      radius_y      <= '0;
      pixel_color   <= COLOR_RESET;
      pc            <= PC_IDLE;
      step_x        <= '0;
      step_y        <= '0;
      decision      <= '0;
      in_region_two <= 1'b0;
      active        <= 1'b0;
      final_point   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CENTER_X:    center_x    <= cfg_data[COORD_BITS-1:0];
          REG_CENTER_Y:    center_y    <= cfg_data[COORD_BITS-1:0];
          REG_RADIUS_X:    radius_x    <= cfg_data[RADIUS_BITS-1:0];
          REG_RADIUS_Y:    radius_y    <= cfg_data[RADIUS_BITS-1:0];
          REG_PIXEL_COLOR: pixel_color <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end

      if (!stall) begin
        pc       <= take ? uw.target : pc + 1'b1;
        decision <= decision_next;

        case (uw.sx_op)
          SX_CLR:  step_x <= '0;
          SX_INC:  step_x <= step_x + 1'b1;
          default: step_x <= step_x;
        endcase

        case (uw.sy_op)
          SY_LOAD: step_y <= ry_ext[COORD_BITS-1:0];
          SY_DEC:  step_y <= step_y - 1'b1;
          default: step_y <= step_y;
        endcase

        case (uw.flag_op)
          FL_START: begin
            in_region_two <= 1'b0;
            active        <= 1'b1;
            final_point   <= 1'b0;
          end
          FL_STOP: begin
            active <= 1'b0;
          end
          FL_REGION2: begin
            in_region_two <= 1'b1;
          end
          FL_CHECK: begin
            // The point where y reaches zero closes the curve.
            final_point <= (step_y == '0);
            if (step_y == '0) begin
              active <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (!stall && uw.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath and output payload registers.
  always_ff @(posedge clk) begin
    if (!stall) begin
      if (uw.wt == WT_IN) begin
        restart_item <= restart;
      end
      if (uw.mul_en) begin
        prod <= mul_full[DEC_W-1:0];
      end
      if (uw.t_load) begin
        hold <= prod;
      end
      if (uw.rx2_load) begin
        rx_sq <= prod[RW2-1:0];
      end
      if (uw.ry2_load) begin
        ry_sq <= prod[RW2-1:0];
      end
      if (uw.emit) begin
        pixel_x       <= sum_x[PIX_W-1:0];
        pixel_y       <= sum_y[PIX_W-1:0];
        color_out     <= pixel_color;
        last_of_point <= (uw.quad == QD_MM);
        curve_done    <= final_point;
      end
    end
  end

endmodule
